>>> hw/rtl/gdsd_pkg.sv
// ----------------------------------------------------------------------------
// gdsd_pkg
// Shared widths, codes, control word layout and microcode program for the
// Gregorian date minus N days block.
// ----------------------------------------------------------------------------
package gdsd_pkg;

  localparam int DAY_W      = 5;
  localparam int MONTH_W    = 4;
  localparam int YEAR_W     = 12;
  localparam int BACK_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int ACC_W      = BACK_W + 1;   // signed running day count
  localparam int CENT_W     = 6;            // year / 100 for a 12-bit year
  localparam int UPC_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR = 1'b1;

  localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 12'd1582;
  localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 12'd2100;

  localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_WAIT,
    OP_CHECK,
    OP_WALK,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_INVALID,
    C_DONE,
    C_OUT_FREE
  } cond_t;

  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t STEP_LOAD  = 3'd0;
  localparam upc_t STEP_WAIT  = 3'd1;
  localparam upc_t STEP_CHECK = 3'd2;
  localparam upc_t STEP_WALK  = 3'd3;
  localparam upc_t STEP_EMIT  = 3'd4;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  jt;
    upc_t  jf;
  } uword_t;

  typedef struct packed {
    op_t  op;
    upc_t step;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic invalid;
    logic done;
    logic out_free;
  } flags_t;

  // days in a month, month codes outside 1..12 give 31 and are rejected elsewhere
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      FEBRUARY:                  len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // microcode program: one control word per step
  function automatic uword_t ucode_rom(input upc_t upc);
    uword_t w;
    unique case (upc)
      STEP_LOAD:  w = '{op: OP_LOAD,  cond: C_IN_VALID, jt: STEP_WAIT,  jf: STEP_LOAD};
      STEP_WAIT:  w = '{op: OP_WAIT,  cond: C_ALWAYS,   jt: STEP_CHECK, jf: STEP_CHECK};
      STEP_CHECK: w = '{op: OP_CHECK, cond: C_INVALID,  jt: STEP_EMIT,  jf: STEP_WALK};
      STEP_WALK:  w = '{op: OP_WALK,  cond: C_DONE,     jt: STEP_EMIT,  jf: STEP_WALK};
      STEP_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_FREE, jt: STEP_LOAD,  jf: STEP_EMIT};
      default:    w = '{op: OP_WAIT,  cond: C_ALWAYS,   jt: STEP_LOAD,  jf: STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/gdsd_if.sv
// ----------------------------------------------------------------------------
// gdsd channel interfaces
// Valid/ready channels for the input date word and the result word.
// ----------------------------------------------------------------------------
interface gdsd_req_if;
  import gdsd_pkg::*;

  logic                valid;
  logic                ready;
  logic [DAY_W-1:0]    day;
  logic [MONTH_W-1:0]  month;
  logic [YEAR_W-1:0]   year;
  logic [BACK_W-1:0]   days_back;

  modport source (output valid, day, month, year, days_back, input ready);
  modport sink   (input valid, day, month, year, days_back, output ready);
endinterface

interface gdsd_rsp_if;
  import gdsd_pkg::*;

  logic                valid;
  logic                ready;
  logic [DAY_W-1:0]    new_day;
  logic [MONTH_W-1:0]  new_month;
  logic [YEAR_W-1:0]   new_year;
  logic [STATUS_W-1:0] status;

  modport source (output valid, new_day, new_month, new_year, status, input ready);
  modport sink   (input valid, new_day, new_month, new_year, status, output ready);
endinterface

>>> hw/rtl/gregorian_date_subtract_days.sv
// ----------------------------------------------------------------------------
// gregorian_date_subtract_days
// Gregorian date minus N days, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// takes one word at a time (day, month, year, days_back) and returns one
// result word (new_day, new_month, new_year, status). status is 0 for ok, 1
// for an invalid start date (month outside 1..12, year outside
// min_year..max_year, day of 0 or past the month's end) and 2 when the walk
// would leave january of year 0; on either error the date fields read 0.
// once a word is taken, the block settles it, checks it, then walks back a
// month at a time until the day lands inside a month (an invalid date goes
// straight from the check to the result); the next word can be taken in the
// cycle after the result is loaded. the time taken is set by the month walk,
// which adds one month length per cycle in a single accumulator. the result
// sits in an output register, so the next word is taken while an earlier result
// waits to be read; a second result then holds in the last step until the first
// one is read. min_year and max_year reset to 1582 and 2100; the user must see
// that they are written only while the block is idle, which the block does not enforce.
module gregorian_date_subtract_days (
  input  logic                              clk,
  input  logic                              rst,
  gdsd_req_if.sink                          req,
  gdsd_rsp_if.source                        rsp,
  input  logic                              cfg_we,
  input  logic [gdsd_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [gdsd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gdsd_pkg::*;

  // year window registers
  logic [YEAR_W-1:0] min_year;
  logic [YEAR_W-1:0] max_year;

  // control word to the datapath, branch conditions back
  ctrl_t  ctrl;
  flags_t flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= MIN_YEAR_RST;
      max_year <= MAX_YEAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MIN_YEAR: min_year <= cfg_data[YEAR_W-1:0];
        CFG_MAX_YEAR: max_year <= cfg_data[YEAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // step counter and control store
  gdsd_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // date registers, leap unit, accumulator and result register
  gdsd_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .min_year (min_year),
    .max_year (max_year),
    .req      (req),
    .rsp      (rsp),
    .flags    (flags)
  );

  // an accepted word always moves the sequencer to the settle step
  a_load_step : assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> ctrl.step == STEP_WAIT)
    else $error("sequencer did not advance after an accepted word");

  // a good result has a nonzero day and a month in 1..12
  a_ok_date : assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_OK |->
      rsp.new_day != '0 && rsp.new_month != '0 && rsp.new_month <= DECEMBER)
    else $error("ok result with an impossible date");

  // an error result has its date fields cleared, and no unknown code
  a_err_zero : assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |->
      (rsp.status == ST_INVALID || rsp.status == ST_UNDERFLOW) &&
      rsp.new_day == '0 && rsp.new_month == '0 && rsp.new_year == '0)
    else $error("error result with date fields set");

  // no word is taken while the month walk runs
  a_walk_busy : assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_WALK |-> !req.ready)
    else $error("input taken during month walk");

endmodule

>>> hw/rtl/gdsd_seq.sv
// ----------------------------------------------------------------------------
// gdsd_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module gdsd_seq (
  input  logic            clk,
  input  logic            rst,
  input  gdsd_pkg::flags_t flags,
  output gdsd_pkg::ctrl_t  ctrl
);
  import gdsd_pkg::*;

  upc_t   upc;
  upc_t   upc_next;
  uword_t uw;
  logic   take;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_LOAD;
    end else begin
      upc <= upc_next;
    end
  end

  always_comb begin
    uw = ucode_rom(upc);
    unique case (uw.cond)
      C_ALWAYS:   take = 1'b1;
      C_IN_VALID: take = flags.in_valid;
      C_INVALID:  take = flags.invalid;
      C_DONE:     take = flags.done;
      C_OUT_FREE: take = flags.out_free;
      default:    take = 1'b1;
    endcase
    upc_next  = take ? uw.jt : uw.jf;
    ctrl.op   = uw.op;
    ctrl.step = upc;
  end

endmodule

>>> hw/rtl/gdsd_dp.sv
// ----------------------------------------------------------------------------
// gdsd_dp
// Datapath: date registers, leap-year unit, day accumulator, result register.
// ----------------------------------------------------------------------------
module gdsd_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  gdsd_pkg::ctrl_t                 ctrl,
  input  logic [gdsd_pkg::YEAR_W-1:0]     min_year,
  input  logic [gdsd_pkg::YEAR_W-1:0]     max_year,
  gdsd_req_if.sink                        req,
  gdsd_rsp_if.source                      rsp,
  output gdsd_pkg::flags_t                flags
);
  import gdsd_pkg::*;

  logic signed [ACC_W-1:0] d;
  logic [DAY_W-1:0]        day_r;
  logic [MONTH_W-1:0]      month_r;
  logic [YEAR_W-1:0]       year_r;
  logic [CENT_W-1:0]       cent_q;
  status_t                 st;

  logic                    o_valid;
  logic [DAY_W-1:0]        o_day;
  logic [MONTH_W-1:0]      o_month;
  logic [YEAR_W-1:0]       o_year;
  logic [STATUS_W-1:0]     o_status;

  logic [24:0]             recip_prod;
  logic [YEAR_W-1:0]       hundreds;
  logic                    cent_year;
  logic                    leap;
  logic [DAY_W-1:0]        cur_len;
  logic [MONTH_W-1:0]      prev_month;
  logic [DAY_W-1:0]        prev_len;
  logic                    invalid;
  logic                    d_pos;
  logic                    at_floor;
  logic                    out_free;
  logic                    emit;

  // year / 100 by reciprocal, exact for 12-bit years; registered before use
  assign recip_prod = {13'b0, year_r} * 25'd5243;

  // q * 100 as shift-add; the remainder is zero when this equals the year
  assign hundreds  = {cent_q, 6'b0} + {1'b0, cent_q, 5'b0} + {4'b0, cent_q, 2'b0};
  assign cent_year = (year_r == hundreds);
  assign leap      = ((year_r[1:0] == 2'b00) && !cent_year) ||
                     (cent_year && (cent_q[1:0] == 2'b00));

  assign cur_len    = month_len(month_r, leap);
  assign prev_month = (month_r == JANUARY) ? DECEMBER : month_r - 4'd1;
  assign prev_len   = month_len(prev_month, leap);

  assign invalid = (month_r == 4'd0) || (month_r > DECEMBER) ||
                   (year_r < min_year) || (year_r > max_year) ||
                   (day_r == 5'd0) || (day_r > cur_len);

  assign d_pos    = !d[ACC_W-1] && (d != '0);
  assign at_floor = (month_r == JANUARY) && (year_r == '0);
  assign out_free = !o_valid || rsp.ready;
  assign emit     = (ctrl.op == OP_EMIT) && out_free;

  assign flags.in_valid = req.valid;
  assign flags.invalid  = invalid;
  assign flags.done     = d_pos || at_floor;
  assign flags.out_free = out_free;

  assign req.ready = (ctrl.op == OP_LOAD);

  // leap lookup trails a year change by a register; only december follows one
  always_ff @(posedge clk) begin
    cent_q <= recip_prod[24:19];
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        if (req.valid) begin
          day_r   <= req.day;
          month_r <= req.month;
          year_r  <= req.year;
          d       <= $signed({12'b0, req.day}) - $signed({1'b0, req.days_back});
          st      <= ST_OK;
        end
      end
      OP_CHECK: begin
        if (invalid) begin
          st <= ST_INVALID;
        end
      end
      OP_WALK: begin
        if (!d_pos) begin
          if (at_floor) begin
            st <= ST_UNDERFLOW;
          end else begin
            month_r <= prev_month;
            if (month_r == JANUARY) begin
              year_r <= year_r - 12'd1;
            end
            d <= d + $signed({12'b0, prev_len});
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_day    <= (st == ST_OK) ? d[DAY_W-1:0] : '0;
      o_month  <= (st == ST_OK) ? month_r : '0;
      o_year   <= (st == ST_OK) ? year_r : '0;
      o_status <= st;
    end
  end

  assign rsp.valid     = o_valid;
  assign rsp.new_day   = o_day;
  assign rsp.new_month = o_month;
  assign rsp.new_year  = o_year;
  assign rsp.status    = o_status;

endmodule

>>> tb/gregorian_date_subtract_days_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_subtract_days_tb
// Self-checking bench for the date minus N days block: a directed table of
// corner dates, then random dates under several year ranges. Each accepted
// result is checked against a typed table entry or a behavioural model in the bench.
// ----------------------------------------------------------------------------
module gregorian_date_subtract_days_tb;
  import gdsd_pkg::*;

  // watchdog: the limit covers the slowest word, the long receiver hold-off
  // and the idle gaps on each side, and still leaves a wide margin
  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int N_PHASES    = 6;
  localparam int PHASE_WORDS = 41;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [BACK_W-1:0]  days_back;
  } date_word_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    status_t            status;
  } date_result_t;

  typedef enum logic {ROW_WORD, ROW_RANGE} row_kind_t;

  // one line of the directed table: either a date word or a new year range
  typedef struct {
    row_kind_t         kind;
    date_word_t        word;
    bit                typed;
    date_result_t      result;
    logic [YEAR_W-1:0] lo;
    logic [YEAR_W-1:0] hi;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  gdsd_req_if req_ch ();
  gdsd_rsp_if rsp_ch ();

  gregorian_date_subtract_days uut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // bench copy of the year range registers, tracks every write
  logic [YEAR_W-1:0] lo_year = MIN_YEAR_RST;
  logic [YEAR_W-1:0] hi_year = MAX_YEAR_RST;

  date_result_t pending_dates[$];
  stim_row_t    directed_rows[$];

  int errors       = 0;
  int words_in     = 0;
  int words_out    = 0;
  int n_ok         = 0;
  int n_invalid    = 0;
  int n_underflow  = 0;
  int n_ranges     = 0;
  int input_stalls = 0;
  int idle_cycles  = 0;

  // sender idling state: bursts with no gaps now and then
  bit send_burst = 1'b0;
  int send_left  = 0;

  logic [YEAR_W-1:0] phase_lo [N_PHASES] = '{12'd0,    12'd1582, 12'd0,
                                             12'd1900, 12'd4000, 12'd3000};
  logic [YEAR_W-1:0] phase_hi [N_PHASES] = '{12'd4095, 12'd2100, 12'd30,
                                             12'd2000, 12'd4095, 12'd2000};

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // behavioural model
  // ---------------------------------------------------------------------------

  // gregorian rule: every 4th year, but not centuries unless divisible by 400
  function automatic bit is_leap_year(input int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int days_in_month(input int m, input int y);
    if (m == 2)
      return is_leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11)
      return 30;
    return 31;
  endfunction

  // expected result of one date word under the current year range
  function automatic date_result_t subtract_days(input date_word_t w);
    date_result_t r;
    int d;
    int m;
    int y;
    r = '{day: '0, month: '0, year: '0, status: ST_INVALID};
    m = w.month;
    y = w.year;
    if (m < 1 || m > 12 || w.year < lo_year || w.year > hi_year ||
        w.day == 0 || w.day > days_in_month(m, y))
      return r;
    d = int'(w.day) - int'(w.days_back);
    // walk back a month at a time until the day lands inside a month
    while (d < 1) begin
      if (m == 1) begin
        if (y == 0) begin
          r.status = ST_UNDERFLOW;
          return r;
        end
        y--;
        m = 12;
      end else begin
        m--;
      end
      d += days_in_month(m, y);
    end
    r.day    = d[DAY_W-1:0];
    r.month  = m[MONTH_W-1:0];
    r.year   = y[YEAR_W-1:0];
    r.status = ST_OK;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // idling, driving and checking
  // ---------------------------------------------------------------------------

  // random gap before the next word, with runs of back-to-back words
  function automatic int draw_wait(inout bit burst, inout int left);
    if (left == 0) begin
      burst = ($urandom_range(0, 3) == 0);
      left  = $urandom_range(8, 24);
    end
    left--;
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  // offer one date word and queue its expected result once it is taken
  task automatic drive_word(input date_word_t w, input bit typed,
                            input date_result_t typed_res);
    int gap;
    date_result_t exp_res;
    gap = draw_wait(send_burst, send_left);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.day       <= w.day;
    req_ch.month     <= w.month;
    req_ch.year      <= w.year;
    req_ch.days_back <= w.days_back;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    exp_res = typed ? typed_res : subtract_days(w);
    pending_dates.push_back(exp_res);
    words_in++;
    case (exp_res.status)
      ST_OK:        n_ok++;
      ST_INVALID:   n_invalid++;
      ST_UNDERFLOW: n_underflow++;
      default:      ;
    endcase
  endtask

  task automatic check_result(input date_result_t got);
    date_result_t exp_res;
    if (pending_dates.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result word %0d/%0d/%0d status %0d",
                 got.day, got.month, got.year, got.status);
      return;
    end
    exp_res = pending_dates.pop_front();
    if (got.day != exp_res.day || got.month != exp_res.month ||
        got.year != exp_res.year || got.status != exp_res.status) begin
      errors++;
      if (errors <= 10)
        $display({"mismatch on result %0d: expected %0d/%0d/%0d status %0d, ",
                  "got %0d/%0d/%0d status %0d"},
                 words_out, exp_res.day, exp_res.month, exp_res.year, exp_res.status,
                 got.day, got.month, got.year, got.status);
    end
  endtask

  // only called with the sender quiet: drain, then a short settle
  task automatic wait_idle();
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // both registers in back-to-back cycles, write enable held across them
  task automatic set_year_range(input logic [YEAR_W-1:0] lo, input logic [YEAR_W-1:0] hi);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_MIN_YEAR;
    cfg_data <= lo;
    @(posedge clk);
    cfg_idx  <= CFG_MAX_YEAR;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we   <= 1'b0;
    lo_year = lo;
    hi_year = hi;
    n_ranges++;
  endtask

  // random date word: mostly well-formed dates in range, some broken, some noise
  task automatic make_random_word(output date_word_t w);
    int kind;
    int pick;
    int m;
    int y;
    int len;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      y = (lo_year <= hi_year) ? $urandom_range(lo_year, hi_year) : $urandom_range(0, 4095);
      m = $urandom_range(1, 12);
      len = days_in_month(m, y);
      pick = $urandom_range(0, 9);
      if (kind >= 70)
        w.day = (pick < 5) ? 5'd0 : DAY_W'(len + $urandom_range(1, 31 - len));
      else if (pick == 0)
        w.day = 5'd1;
      else if (pick == 1)
        w.day = DAY_W'(len);
      else
        w.day = DAY_W'($urandom_range(1, len));
      w.month = MONTH_W'(m);
      w.year  = YEAR_W'(y);
      // keep most walks short, a few run the full 16-bit span
      pick = $urandom_range(0, 99);
      if (pick < 55)
        w.days_back = BACK_W'($urandom_range(0, 60));
      else if (pick < 88)
        w.days_back = BACK_W'($urandom_range(0, 1500));
      else if (pick < 97)
        w.days_back = BACK_W'($urandom_range(0, 65535));
      else
        w.days_back = 16'hFFFF;
    end else begin
      w.day       = DAY_W'($urandom);
      w.month     = MONTH_W'($urandom);
      w.year      = YEAR_W'($urandom);
      w.days_back = BACK_W'($urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed table rows
  // ---------------------------------------------------------------------------

  task automatic add_word(input int d, input int m, input int y, input int b);
    stim_row_t row;
    row.kind   = ROW_WORD;
    row.word   = '{day: DAY_W'(d), month: MONTH_W'(m), year: YEAR_W'(y),
                   days_back: BACK_W'(b)};
    row.typed  = 1'b0;
    row.result = '0;
    row.lo     = '0;
    row.hi     = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_typed(input int d, input int m, input int y, input int b,
                           input int rd, input int rm, input int ry, input status_t st);
    stim_row_t row;
    row.kind   = ROW_WORD;
    row.word   = '{day: DAY_W'(d), month: MONTH_W'(m), year: YEAR_W'(y),
                   days_back: BACK_W'(b)};
    row.typed  = 1'b1;
    row.result = '{day: DAY_W'(rd), month: MONTH_W'(rm), year: YEAR_W'(ry),
                   status: st};
    row.lo     = '0;
    row.hi     = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_range(input int lo, input int hi);
    stim_row_t row;
    row.kind   = ROW_RANGE;
    row.word   = '0;
    row.typed  = 1'b0;
    row.result = '0;
    row.lo     = YEAR_W'(lo);
    row.hi     = YEAR_W'(hi);
    directed_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // watchdog and handshake monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && !req_ch.ready)
        input_stalls <= input_stalls + 1;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random back-pressure plus two long hold-offs that let the
  // block fill its output register and stall the input
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int wait_cycles;
    bit burst;
    int left;
    date_result_t got;
    burst = 1'b0;
    left  = 0;
    while (rst) @(posedge clk);
    forever begin
      if (words_out == 40 || words_out == 200)
        wait_cycles = HOLD_CYCLES;
      else
        wait_cycles = draw_wait(burst, left);
      if (wait_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      got.day    = rsp_ch.new_day;
      got.month  = rsp_ch.new_month;
      got.year   = rsp_ch.new_year;
      got.status = status_t'(rsp_ch.status);
      words_out++;
      check_result(got);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    date_word_t w;
    req_ch.valid     <= 1'b0;
    req_ch.day       <= '0;
    req_ch.month     <= '0;
    req_ch.year      <= '0;
    req_ch.days_back <= '0;
    rsp_ch.ready     <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_MIN_YEAR;
    cfg_data         <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset range 1582..2100: range edges, leap rules, bad days and months
    add_typed(15, 10, 1582, 0, 15, 10, 1582, ST_OK);
    add_typed(1, 1, 1581, 1, 0, 0, 0, ST_INVALID);
    add_typed(31, 12, 2100, 0, 31, 12, 2100, ST_OK);
    add_typed(1, 1, 2101, 0, 0, 0, 0, ST_INVALID);
    add_typed(29, 2, 1900, 0, 0, 0, 0, ST_INVALID);    // century, not leap
    add_typed(29, 2, 2000, 0, 29, 2, 2000, ST_OK);     // divisible by 400
    add_word(1, 3, 2000, 1);
    add_word(1, 3, 1900, 1);
    add_typed(0, 6, 2000, 5, 0, 0, 0, ST_INVALID);     // day zero
    add_typed(31, 4, 2000, 5, 0, 0, 0, ST_INVALID);    // past month end
    add_typed(31, 0, 2000, 5, 0, 0, 0, ST_INVALID);
    add_typed(31, 13, 2000, 5, 0, 0, 0, ST_INVALID);
    add_typed(31, 15, 2000, 5, 0, 0, 0, ST_INVALID);
    add_word(1, 1, 2000, 1);                           // crosses a year
    // full range: walks that run into year 0 and the top of the year field
    add_range(0, 4095);
    add_typed(1, 1, 0, 1, 0, 0, 0, ST_UNDERFLOW);
    add_typed(31, 1, 0, 30, 1, 1, 0, ST_OK);
    add_typed(31, 1, 0, 31, 0, 0, 0, ST_UNDERFLOW);
    add_typed(29, 2, 0, 65535, 0, 0, 0, ST_UNDERFLOW);
    add_word(31, 12, 4095, 65535);
    add_typed(31, 12, 4095, 0, 31, 12, 4095, ST_OK);
    add_word(31, 12, 179, 65535);
    // empty range rejects every date
    add_range(2000, 1999);
    add_typed(1, 1, 2000, 0, 0, 0, 0, ST_INVALID);
    // single-year ranges at both ends
    add_range(4095, 4095);
    add_word(1, 1, 4095, 1);
    add_typed(31, 12, 4094, 0, 0, 0, 0, ST_INVALID);
    add_range(0, 0);
    add_word(15, 6, 0, 100);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_RANGE) begin
        req_ch.valid <= 1'b0;
        wait_idle();
        set_year_range(directed_rows[i].lo, directed_rows[i].hi);
      end else begin
        drive_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);
      end
    end

    // random phases, one year range each, the registers only touched when idle
    for (int p = 0; p < N_PHASES; p++) begin
      req_ch.valid <= 1'b0;
      wait_idle();
      set_year_range(phase_lo[p], phase_hi[p]);
      repeat (PHASE_WORDS) begin
        make_random_word(w);
        drive_word(w, 1'b0, '0);
      end
    end
    req_ch.valid <= 1'b0;

    while (pending_dates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d date words in, %0d results out: %0d ok, %0d invalid, %0d underflow",
             words_in, words_out, n_ok, n_invalid, n_underflow);
    $display("%0d year range settings, input held off for %0d cycles, %0d errors",
             n_ranges, input_stalls, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
